/* src/llip_pkg.sv */
// Package for the lossless inverse pixel predictor: mode codes, item kinds,
// queue entry type and the per-byte arithmetic helpers.
// No dependencies; used by every module of the block.
package llip_pkg;

  // Stream widths
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned IN_FIELD_W = 4 + 4 * PIX_W;
  localparam int unsigned IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = PIX_W;
  localparam int unsigned DT_W       = 10;  // four byte differences, 4 * 255
  localparam int unsigned QUEUE_DEPTH = 2;  // 2..16

  localparam logic [PIX_W-1:0] OPAQUE_BLACK = 32'hff00_0000;

  // Predictor mode codes
  localparam logic [3:0] MODE_BLACK    = 4'd0;
  localparam logic [3:0] MODE_LEFT     = 4'd1;
  localparam logic [3:0] MODE_TOP      = 4'd2;
  localparam logic [3:0] MODE_TR       = 4'd3;
  localparam logic [3:0] MODE_TL       = 4'd4;
  localparam logic [3:0] MODE_AVG_TLT  = 4'd8;
  localparam logic [3:0] MODE_AVG_TTR  = 4'd9;
  localparam logic [3:0] MODE_AVG_ALL  = 4'd10;
  localparam logic [3:0] MODE_SELECT   = 4'd11;
  localparam logic [3:0] MODE_CLAMP    = 4'd12;

  // What the back end has to do with a request
  typedef enum logic [2:0] {
    KIND_FIXED,    // prediction fully known at the front
    KIND_LEFT,     // prediction is the left neighbour
    KIND_AVG_ALL,  // average of avg(L,TL) and avg(T,TR)
    KIND_SELECT,   // L or T by gradient comparison
    KIND_CLAMP,    // clamp(L + T - TL)
    KIND_PASS      // unsupported mode, residual passes through
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [PIX_W-1:0]  pred;      // fixed prediction, or avg(T,TR) for KIND_AVG_ALL
    logic [PIX_W-1:0]  top;
    logic [PIX_W-1:0]  top_left;
    logic [DT_W-1:0]   dt;        // sum of |T - TL| over channels
    logic [PIX_W-1:0]  residual;
    logic              last;
  } q_entry_t;

  function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8:1];
  endfunction

  function automatic logic [PIX_W-1:0] avg32(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      r[8*k +: 8] = avg8(a[8*k +: 8], b[8*k +: 8]);
    end
    return r;
  endfunction

  function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Sum of absolute channel differences, at most 1020
  function automatic logic [DT_W-1:0] grad32(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
    logic [DT_W-1:0] s;
    s = '0;
    for (int k = 0; k < 4; k++) begin
      s = s + DT_W'(absdiff8(a[8*k +: 8], b[8*k +: 8]));
    end
    return s;
  endfunction

  function automatic logic [7:0] clamp8(input logic [7:0] l, input logic [7:0] t,
                                        input logic [7:0] tl);
    logic signed [9:0] v;
    v = $signed({2'b00, l}) + $signed({2'b00, t}) - $signed({2'b00, tl});
    if (v < 0) begin
      return 8'd0;
    end else if (v > 10'sd255) begin
      return 8'hff;
    end
    return v[7:0];
  endfunction

endpackage

/* src/lossless_inverse_pixel_predictor_unit.sv */
// Lossless inverse pixel predictor: rebuilds ARGB pixels from residuals.
// Usage:
//   Slave stream s_*: one request per pixel, tdata carries mode, residual and
//   the top, top-left and top-right neighbours; tlast marks the end of a run.
//   Master stream m_*: the rebuilt pixel in tdata, tuser[0] set when the mode
//   is not supported (the residual is then passed unchanged), tlast echoed.
// Path: an accepted request is written into the queue and from there loaded
//   into the output register, which drives m_tvalid.
// Throughput: one pixel per cycle while m_tready is high. The rate is set
//   by the left-neighbour loop in the back end: prediction and byte add
//   feed the left register combinationally. The front end decodes the mode
//   and precomputes the row-above parts; a short queue sits between the two.
// Stalls: when m_tready is low the output register holds its result, the
//   queue fills and then s_tready drops; no request is lost.
// Reset (rst, synchronous, high) empties the queue and the output register
//   and sets the left neighbour to opaque black; the left neighbour carries
//   across runs until the next reset.
// Depends on llip_pkg, llip_front, llip_queue, llip_back.
module lossless_inverse_pixel_predictor_unit
  import llip_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH  // 2..16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // func[3:0], residual[35:4], top[67:36], top_left[99:68],
  // top_right[131:100], zero pad [135:132]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,   // run_end
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // pixel[31:0]
  output logic [0:0]            m_tuser,   // unsupported[0]
  output logic                  m_tlast    // last
);

  q_entry_t front_entry;
  q_entry_t q_entry;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_valid;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  llip_front u_front (
    .fields  (s_tdata[IN_FIELD_W-1:0]),
    .run_end (s_tlast),
    .entry   (front_entry)
  );

  llip_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (front_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_entry (q_entry),
    .valid    (q_valid)
  );

  llip_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

`ifndef NO_ASSERTIONS
  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("request pushed into full queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("request popped from empty queue");

  // Output register is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid straight after reset");

  // A stalled result is never dropped by a new pop
  a_stall_no_pop: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !q_pop)
    else $error("queue popped while result stalled");
`endif

endmodule

/* src/llip_front.sv */
// Front end: unpacks an incoming request, decodes the predictor mode and
// works out everything that does not need the left neighbour.
// Depends on llip_pkg.
module llip_front
  import llip_pkg::*;
(
  input  logic [IN_FIELD_W-1:0] fields,  // func, residual, top, top_left, top_right
  input  logic                  run_end,
  output q_entry_t              entry
);

  logic [3:0]       func;
  logic [PIX_W-1:0] residual;
  logic [PIX_W-1:0] top;
  logic [PIX_W-1:0] top_left;
  logic [PIX_W-1:0] top_right;

  // Unpack the request fields
  assign func      = fields[3:0];
  assign residual  = fields[4 +: PIX_W];
  assign top       = fields[4 + PIX_W +: PIX_W];
  assign top_left  = fields[4 + 2 * PIX_W +: PIX_W];
  assign top_right = fields[4 + 3 * PIX_W +: PIX_W];

  // Classify the mode and precompute the fixed part of the prediction
  always_comb begin
    entry.top      = top;
    entry.top_left = top_left;
    entry.residual = residual;
    entry.last     = run_end;
    entry.dt       = grad32(top, top_left);
    entry.pred     = '0;
    unique case (func)
      MODE_BLACK: begin
        entry.kind = KIND_FIXED;
        entry.pred = OPAQUE_BLACK;
      end
      MODE_LEFT: begin
        entry.kind = KIND_LEFT;
      end
      MODE_TOP: begin
        entry.kind = KIND_FIXED;
        entry.pred = top;
      end
      MODE_TR: begin
        entry.kind = KIND_FIXED;
        entry.pred = top_right;
      end
      MODE_TL: begin
        entry.kind = KIND_FIXED;
        entry.pred = top_left;
      end
      MODE_AVG_TLT: begin
        entry.kind = KIND_FIXED;
        entry.pred = avg32(top_left, top);
      end
      MODE_AVG_TTR: begin
        entry.kind = KIND_FIXED;
        entry.pred = avg32(top, top_right);
      end
      MODE_AVG_ALL: begin
        entry.kind = KIND_AVG_ALL;
        entry.pred = avg32(top, top_right);
      end
      MODE_SELECT: begin
        entry.kind = KIND_SELECT;
      end
      MODE_CLAMP: begin
        entry.kind = KIND_CLAMP;
      end
      default: begin
        entry.kind = KIND_PASS;
      end
    endcase
  end

endmodule

/* src/llip_queue.sv */
// Short request queue between the front and back ends.
// Depends on llip_pkg for the entry type.
module llip_queue
  import llip_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t wr_entry,
  output logic     full,
  input  logic     pop,
  output q_entry_t rd_entry,
  output logic     valid
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  q_entry_t          mem [Depth];
  logic [IdxW-1:0]   wr_ptr;
  logic [IdxW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign full     = (count == CntW'(Depth));
  assign valid    = (count != '0);
  assign rd_entry = mem[rd_ptr];

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IdxW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IdxW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/llip_back.sv */
// Back end: finishes the prediction with the left neighbour, adds the
// residual per byte and holds the result in the output register.
// Depends on llip_pkg.
module llip_back
  import llip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  q_entry_t              q_entry,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [0:0]            m_tuser,
  output logic                  m_tlast
);

  logic [PIX_W-1:0] left_pixel;
  logic [PIX_W-1:0] pred;
  logic [PIX_W-1:0] sum;
  logic [PIX_W-1:0] pixel_next;
  logic [DT_W-1:0]  dl;

  assign dl    = grad32(left_pixel, q_entry.top_left);
  assign q_pop = q_valid && (!m_tvalid || m_tready);

  // Finish the prediction
  always_comb begin
    pred = q_entry.pred;
    unique case (q_entry.kind)
      KIND_FIXED:   pred = q_entry.pred;
      KIND_LEFT:    pred = left_pixel;
      KIND_AVG_ALL: pred = avg32(avg32(left_pixel, q_entry.top_left), q_entry.pred);
      KIND_SELECT:  pred = (dl > q_entry.dt) ? left_pixel : q_entry.top;
      KIND_CLAMP: begin
        for (int k = 0; k < 4; k++) begin
          pred[8*k +: 8] = clamp8(left_pixel[8*k +: 8], q_entry.top[8*k +: 8],
                                  q_entry.top_left[8*k +: 8]);
        end
      end
      KIND_PASS:    pred = '0;
      default:      pred = q_entry.pred;
    endcase
  end

  // Add residual modulo 256 per channel
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum[8*k +: 8] = q_entry.residual[8*k +: 8] + pred[8*k +: 8];
    end
    pixel_next = (q_entry.kind == KIND_PASS) ? q_entry.residual : sum;
  end

  // Hold the left neighbour and the output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel <= OPAQUE_BLACK;
      m_tvalid   <= 1'b0;
    end else begin
      if (q_pop) begin
        left_pixel <= pixel_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid   <= 1'b0;
      end
    end
  end

  // Load the output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_tdata    <= pixel_next;
      m_tuser[0] <= (q_entry.kind == KIND_PASS);
      m_tlast    <= q_entry.last;
    end
  end

endmodule

/* tb/sv/tb_lossless_inverse_pixel_predictor_unit.sv */
// Self-checking testbench for the lossless inverse pixel predictor unit.
// Drives directed and random pixel requests, predicts each rebuilt pixel in
// place and checks the output stream. Depends on llip_pkg and the unit.
module tb_lossless_inverse_pixel_predictor_unit;
  import llip_pkg::*;

  // Modes the unit must flag as unsupported
  localparam logic [3:0] MODE_UNSUP_5  = 4'd5;
  localparam logic [3:0] MODE_UNSUP_6  = 4'd6;
  localparam logic [3:0] MODE_UNSUP_7  = 4'd7;
  localparam logic [3:0] MODE_UNSUP_13 = 4'd13;
  localparam logic [3:0] MODE_UNDEF_14 = 4'd14;
  localparam logic [3:0] MODE_UNDEF_15 = 4'd15;

  localparam int RANDOM_ITEMS = 430;
  localparam int HOLD_AT      = 60;   // requests accepted before the long hold-off
  localparam int HOLD_CYCLES  = 80;
  localparam int CALM_FROM    = 250;  // window with no idling on either side
  localparam int CALM_TO      = 330;

  typedef struct {
    logic [3:0]       mode;
    logic [PIX_W-1:0] res;
    logic [PIX_W-1:0] top_px;
    logic [PIX_W-1:0] tl_px;
    logic [PIX_W-1:0] tr_px;
    logic             run_end;
    bit               typed;      // expected pixel written into the row
    logic [PIX_W-1:0] want_pix;
    logic             want_unsup;
  } stim_row_t;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             unsup;
    logic             last;
  } rebuilt_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]            m_tuser;
  logic                  m_tlast;

  // Typed expectation travelling with the request on offer
  bit               offer_typed;
  logic [PIX_W-1:0] offer_pix;
  logic             offer_unsup;

  stim_row_t        rows[$];
  rebuilt_t         pending_pixels[$];
  logic [PIX_W-1:0] left_px;
  int               n_accepted;
  int               failures;
  bit               calm;

  lossless_inverse_pixel_predictor_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  assign calm = (n_accepted >= CALM_FROM) && (n_accepted < CALM_TO);

  // Floor average of two pixels, byte by byte
  function automatic logic [PIX_W-1:0] mean_px(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      r[8*k +: 8] = 8'((int'(a[8*k +: 8]) + int'(b[8*k +: 8])) / 2);
    end
    return r;
  endfunction

  // Rebuild one pixel from its residual, neighbours and the left pixel
  function automatic rebuilt_t rebuild(input logic [3:0] mode, input logic [PIX_W-1:0] res,
                                       input logic [PIX_W-1:0] t, input logic [PIX_W-1:0] tl,
                                       input logic [PIX_W-1:0] tr,
                                       input logic [PIX_W-1:0] lft);
    logic [PIX_W-1:0] pred;
    rebuilt_t         o;
    int               dl;
    int               dt;
    int               v;
    pred    = '0;
    o.unsup = 1'b0;
    o.last  = 1'b0;
    dl      = 0;
    dt      = 0;
    case (mode)
      MODE_BLACK:   pred = OPAQUE_BLACK;
      MODE_LEFT:    pred = lft;
      MODE_TOP:     pred = t;
      MODE_TR:      pred = tr;
      MODE_TL:      pred = tl;
      MODE_AVG_TLT: pred = mean_px(tl, t);
      MODE_AVG_TTR: pred = mean_px(t, tr);
      MODE_AVG_ALL: pred = mean_px(mean_px(lft, tl), mean_px(t, tr));
      MODE_SELECT: begin
        for (int k = 0; k < 4; k++) begin
          v  = int'(lft[8*k +: 8]) - int'(tl[8*k +: 8]);
          dl += (v < 0) ? -v : v;
          v  = int'(t[8*k +: 8]) - int'(tl[8*k +: 8]);
          dt += (v < 0) ? -v : v;
        end
        pred = (dl > dt) ? lft : t;
      end
      MODE_CLAMP: begin
        for (int k = 0; k < 4; k++) begin
          v = int'(lft[8*k +: 8]) + int'(t[8*k +: 8]) - int'(tl[8*k +: 8]);
          pred[8*k +: 8] = (v < 0) ? 8'h00 : ((v > 255) ? 8'hff : 8'(v));
        end
      end
      default: o.unsup = 1'b1;
    endcase
    if (o.unsup) begin
      o.pix = res;
    end else begin
      for (int k = 0; k < 4; k++) begin
        o.pix[8*k +: 8] = res[8*k +: 8] + pred[8*k +: 8];
      end
    end
    return o;
  endfunction

  task automatic add_row(input logic [3:0] mode, input logic [PIX_W-1:0] res,
                         input logic [PIX_W-1:0] t, input logic [PIX_W-1:0] tl,
                         input logic [PIX_W-1:0] tr, input logic run_end,
                         input bit typed, input logic [PIX_W-1:0] want_pix,
                         input logic want_unsup);
    stim_row_t r;
    r.mode       = mode;
    r.res        = res;
    r.top_px     = t;
    r.tl_px      = tl;
    r.tr_px      = tr;
    r.run_end    = run_end;
    r.typed      = typed;
    r.want_pix   = want_pix;
    r.want_unsup = want_unsup;
    rows.push_back(r);
  endtask

  // Byte biased towards the extremes and the middle
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'(8'h7e + $urandom_range(3));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
  endfunction

  // Offer one request, with random idle cycles first, and wait for acceptance
  task automatic send_pixel(input stim_row_t r);
    while (!calm && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid    <= 1'b1;
    s_tdata     <= IN_DATA_W'({r.tr_px, r.tl_px, r.top_px, r.res, r.mode});
    s_tlast     <= r.run_end;
    offer_typed <= r.typed;
    offer_pix   <= r.want_pix;
    offer_unsup <= r.want_unsup;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Predict accepted requests and check delivered pixels
  always @(posedge clk) begin : scoreboard
    rebuilt_t got;
    rebuilt_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_pixels.size() == 0) begin
          $error("pixel %h delivered with no request outstanding", m_tdata);
          failures++;
        end else begin
          want = pending_pixels.pop_front();
          if (m_tdata !== want.pix) begin
            $error("pixel: expected %h, got %h", want.pix, m_tdata);
            failures++;
          end
          if (m_tuser[0] !== want.unsup) begin
            $error("unsupported: expected %b, got %b", want.unsup, m_tuser[0]);
            failures++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %b, got %b", want.last, m_tlast);
            failures++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        got = rebuild(s_tdata[3:0], s_tdata[35:4], s_tdata[67:36], s_tdata[99:68],
                      s_tdata[131:100], left_px);
        left_px  = got.pix;
        got.last = s_tlast;
        if (offer_typed) begin
          got.pix   = offer_pix;
          got.unsup = offer_unsup;
        end
        pending_pixels.push_back(got);
        n_accepted++;
      end
    end
  end

  // Receiver: random stalls, one long hold-off, and a calm window
  initial begin : receiver
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && n_accepted >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (calm) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 20);
      end
    end
  end

  initial begin : stimulus
    stim_row_t r;
    logic [3:0] live_modes[10];
    logic [3:0] dead_modes[6];
    live_modes = '{MODE_BLACK, MODE_LEFT, MODE_TOP, MODE_TR, MODE_TL, MODE_AVG_TLT,
                   MODE_AVG_TTR, MODE_AVG_ALL, MODE_SELECT, MODE_CLAMP};
    dead_modes = '{MODE_UNSUP_5, MODE_UNSUP_6, MODE_UNSUP_7, MODE_UNSUP_13,
                   MODE_UNDEF_14, MODE_UNDEF_15};
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    offer_typed = 1'b0;
    offer_pix   = '0;
    offer_unsup = 1'b0;
    left_px     = OPAQUE_BLACK;
    n_accepted  = 0;
    failures    = 0;
    rst         = 1'b1;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed: left neighbour after reset, wrap-around, unsupported modes, fixed and averaging modes
    add_row(MODE_LEFT, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1, 32'hff00_0000, 1'b0);
    add_row(MODE_BLACK, 32'h00ff_ffff, 32'h0, 32'h0, 32'h0, 1'b0, 1, 32'hffff_ffff, 1'b0);
    add_row(MODE_BLACK, 32'h0101_0101, 32'h0, 32'h0, 32'h0, 1'b1, 1, 32'h0001_0101, 1'b0);
    add_row(MODE_UNSUP_5, 32'h1234_5678, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
            1'b0, 1, 32'h1234_5678, 1'b1);
    add_row(MODE_UNSUP_6, 32'hffff_ffff, 32'h0, 32'h0, 32'h0, 1'b1, 1, 32'hffff_ffff, 1'b1);
    add_row(MODE_UNSUP_7, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1, 32'h0, 1'b1);
    add_row(MODE_UNSUP_13, 32'ha5a5_a5a5, 32'h1, 32'h2, 32'h3, 1'b0, 1, 32'ha5a5_a5a5, 1'b1);
    add_row(MODE_UNDEF_14, 32'h5a5a_5a5a, 32'h0, 32'h0, 32'h0, 1'b0, 1, 32'h5a5a_5a5a, 1'b1);
    add_row(MODE_UNDEF_15, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1, 32'h0, 1'b1);
    add_row(MODE_TOP, 32'hffff_ffff, 32'h0101_0101, 32'h0, 32'h0, 1'b0, 1, 32'h0, 1'b0);
    add_row(MODE_TR, 32'h0, 32'h0, 32'h0, 32'hffff_ffff, 1'b0, 1, 32'hffff_ffff, 1'b0);
    add_row(MODE_TL, 32'h8080_8080, 32'h0, 32'h8080_8080, 32'h0, 1'b0, 1, 32'h0, 1'b0);
    add_row(MODE_AVG_TTR, 32'h0, 32'hffff_ffff, 32'h0, 32'h0, 1'b0, 1, 32'h7f7f_7f7f, 1'b0);
    add_row(MODE_AVG_TLT, 32'h0, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 1'b0, 0, 32'h0, 1'b0);
    add_row(MODE_AVG_TLT, 32'h0, 32'h01ff_00ff, 32'hff00_ff00, 32'h0, 1'b0, 0, 32'h0, 1'b0);
    add_row(MODE_AVG_ALL, 32'h1357_9bdf, 32'hff01_80fe, 32'h00ff_7f01, 32'hffff_0102,
            1'b1, 0, 32'h0, 1'b0);
    // Select: left clearly closer, left and top equally close, top closer
    add_row(MODE_BLACK, 32'h0100_0000, 32'h0, 32'h0, 32'h0, 1'b0, 0, 32'h0, 1'b0);
    add_row(MODE_SELECT, 32'h0, 32'h0100_0000, 32'h0, 32'h0, 1'b0, 0, 32'h0, 1'b0);
    add_row(MODE_SELECT, 32'h0, 32'h0000_0001, 32'h0, 32'h0, 1'b0, 0, 32'h0, 1'b0);
    add_row(MODE_SELECT, 32'h1020_3040, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 1'b0, 0,
            32'h0, 1'b0);
    // Clamp: saturate high, land exactly on zero, stay in range
    add_row(MODE_BLACK, 32'h00ff_ffff, 32'h0, 32'h0, 32'h0, 1'b0, 0, 32'h0, 1'b0);
    add_row(MODE_CLAMP, 32'h0, 32'hffff_ffff, 32'h0, 32'h0, 1'b0, 0, 32'h0, 1'b0);
    add_row(MODE_CLAMP, 32'h0, 32'h0, 32'hffff_ffff, 32'h0, 1'b0, 0, 32'h0, 1'b0);
    add_row(MODE_CLAMP, 32'h0102_0304, 32'h4080_c0ff, 32'h2040_6080, 32'h0, 1'b1, 0,
            32'h0, 1'b0);
    add_row(MODE_LEFT, 32'h8000_0001, 32'h0, 32'h0, 32'h0, 1'b0, 0, 32'h0, 1'b0);

    foreach (rows[i]) send_pixel(rows[i]);

    // Random: mostly supported modes, neighbours sometimes alike
    repeat (RANDOM_ITEMS) begin
      r.mode    = ($urandom_range(99) < 85) ? live_modes[$urandom_range(9)]
                                            : dead_modes[$urandom_range(5)];
      r.res     = ($urandom_range(3) == 0) ? pick_pixel() : $urandom;
      r.top_px  = pick_pixel();
      r.tl_px   = pick_pixel();
      r.tr_px   = pick_pixel();
      r.run_end = ($urandom_range(7) == 0);
      r.typed   = 0;
      r.want_pix   = '0;
      r.want_unsup = 1'b0;
      case ($urandom_range(7))
        0: r.top_px = r.tl_px;
        1: r.tl_px  = r.top_px ^ PIX_W'($urandom_range(3));
        2: r.top_px = left_px;
        default: ;
      endcase
      send_pixel(r);
    end
    s_tvalid <= 1'b0;

    // Drain the pending pixels, then check for anything unexpected
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
src/llip_pkg.sv
src/llip_front.sv
src/llip_queue.sv
src/llip_back.sv
src/lossless_inverse_pixel_predictor_unit.sv
tb/sv/tb_lossless_inverse_pixel_predictor_unit.sv
